FILE: sv/d2c_pkg.sv
// ----------------------------------------------------------------------------
// d2c_pkg
// Shared constants, twiddle ROM and control types of the 2-D DFT coefficient
// engine.
// ----------------------------------------------------------------------------
package d2c_pkg;

  localparam int DIM_DEF    = 16;
  localparam int IDX_W      = 4;
  localparam int SAMPLE_W   = 16;
  localparam int TW_W       = 16;
  localparam int ROM_IDX_W  = 6;
  localparam int ROM_POINTS = 64;
  localparam int QUARTER    = ROM_POINTS / 4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [TW_W-1:0] QSINE [QUARTER+1] = '{
    16'd0,     16'd1606,  16'd3196,  16'd4756,  16'd6270,  16'd7723,
    16'd9102,  16'd10394, 16'd11585, 16'd12665, 16'd13623, 16'd14449,
    16'd15137, 16'd15679, 16'd16069, 16'd16305, 16'd16384
  };

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctl_t;

  function automatic logic signed [TW_W-1:0] rom_sine(input logic [ROM_IDX_W-1:0] j);
    logic [1:0]      q;
    logic [3:0]      r;
    logic [4:0]      rr;
    logic [TW_W-1:0] v;
    q  = j[5:4];
    r  = j[3:0];
    rr = 5'(QUARTER) - {1'b0, r};
    case (q)
      2'd0:    v = QSINE[{1'b0, r}];
      2'd1:    v = QSINE[rr];
      2'd2:    v = TW_W'(0) - QSINE[{1'b0, r}];
      default: v = TW_W'(0) - QSINE[rr];
    endcase
    return $signed(v);
  endfunction

endpackage

FILE: sv/d2c_if.sv
// ----------------------------------------------------------------------------
// d2c_if
// Valid/ready channels of the 2-D DFT coefficient engine: one for input
// words, one for result words.
// ----------------------------------------------------------------------------
interface d2c_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [d2c_pkg::IDX_W-1:0]           row_index;
  logic [d2c_pkg::IDX_W-1:0]           col_index;
  logic signed [d2c_pkg::SAMPLE_W-1:0] sample_value;
  logic [d2c_pkg::IDX_W-1:0]           freq_row;
  logic [d2c_pkg::IDX_W-1:0]           freq_col;

  modport source (output valid, func, row_index, col_index, sample_value, freq_row,
                  freq_col, input ready);
  modport sink   (input valid, func, row_index, col_index, sample_value, freq_row,
                  freq_col, output ready);
endinterface

interface d2c_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [d2c_pkg::SAMPLE_W-1:0] real_part;
  logic signed [d2c_pkg::SAMPLE_W-1:0] imag_part;

  modport source (output valid, real_part, imag_part, input ready);
  modport sink   (input valid, real_part, imag_part, output ready);
endinterface

FILE: sv/d2c_mac.sv
// ----------------------------------------------------------------------------
// d2c_mac
// Complex multiply-accumulate unit: registered products of a real sample
// with a cosine and a sine twiddle; wide accumulators add cos, subtract sin.
// ----------------------------------------------------------------------------
module d2c_mac #(
  parameter int DIM = d2c_pkg::DIM_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  d2c_pkg::mac_ctl_t                            ctl,
  input  logic signed [d2c_pkg::SAMPLE_W-1:0]          sample,
  input  logic signed [d2c_pkg::TW_W-1:0]              tw_cos,
  input  logic signed [d2c_pkg::TW_W-1:0]              tw_sin,
  output logic signed [30+2*$clog2(DIM):0]             acc_re,
  output logic signed [30+2*$clog2(DIM):0]             acc_im,
  output logic                                         done
);
  import d2c_pkg::*;

  localparam int DIM_LOG = $clog2(DIM);
  localparam int ACC_W   = 31 + 2 * DIM_LOG;
  localparam int PROD_W  = SAMPLE_W + TW_W;

  logic signed [PROD_W-1:0] p_re_r;
  logic signed [PROD_W-1:0] p_im_r;
  logic                     pv_r;
  logic                     plast_r;
  logic signed [ACC_W-1:0]  acc_re_r;
  logic signed [ACC_W-1:0]  acc_im_r;
  logic                     done_r;
  logic signed [ACC_W-1:0]  ext_re;
  logic signed [ACC_W-1:0]  ext_im;

  assign ext_re = {{(ACC_W-PROD_W){p_re_r[PROD_W-1]}}, p_re_r};
  assign ext_im = {{(ACC_W-PROD_W){p_im_r[PROD_W-1]}}, p_im_r};

  always_ff @(posedge clk) begin
    p_re_r <= sample * tw_cos;
    p_im_r <= sample * tw_sin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      plast_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      pv_r    <= ctl.valid;
      plast_r <= ctl.valid && ctl.last;
      done_r  <= pv_r && plast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pv_r) begin
      acc_re_r <= acc_re_r + ext_re;
      acc_im_r <= acc_im_r - ext_im;
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;
  assign done   = done_r;

endmodule

FILE: sv/dft2d_coefficient.sv
// ----------------------------------------------------------------------------
// dft2d_coefficient
// Direct 2-D DFT coefficient engine over a DIM by DIM matrix of Q8.8 samples.
// ----------------------------------------------------------------------------
// Input words arrive on in_ch. A word with func = load writes sample_value at
// (row_index, col_index); a position outside the matrix is dropped. A word
// with func = query starts a walk over all DIM*DIM stored samples, one complex
// multiply-accumulate per cycle through a single MAC unit fed by the sample
// memory read port. Read sample and twiddles, then MAC products, then the
// accumulators with the done flag are registered. in_ch.ready stays low during
// the walk and rises with the result, so no further word is taken until then;
// loads can be taken every cycle while idle. The result is the sum divided by
// DIM*DIM, truncated toward zero and saturated to Q8.8, presented on out_ch
// as real_part and imag_part. The result waits in an output register: a new
// word may be accepted while it waits, and a finished query holds until the
// register frees up when out_ch stalls. Reset clears control state only; the
// sample memory holds garbage until written, and every entry must be loaded
// before a query reads it.
// ----------------------------------------------------------------------------
module dft2d_coefficient #(
  parameter int DIM = d2c_pkg::DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  d2c_in_if.sink    in_ch,
  d2c_out_if.source out_ch
);
  import d2c_pkg::*;

  localparam int DIM_LOG   = $clog2(DIM);
  localparam int ADDR_W    = 2 * DIM_LOG;
  localparam int DEPTH     = DIM * DIM;
  localparam int ACC_W     = 31 + 2 * DIM_LOG;
  localparam int SHIFT     = 2 * DIM_LOG + 14;
  localparam int ROM_SHIFT = ROM_IDX_W - DIM_LOG;

  localparam logic [ADDR_W-1:0]  ADDR_LAST = '1;
  localparam logic [DIM_LOG-1:0] COL_LAST  = '1;
  localparam logic [ACC_W-1:0]   BIAS      = (ACC_W'(1) << SHIFT) - ACC_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic signed [SAMPLE_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0]           cnt_r;
  logic [DIM_LOG-1:0]          k_r;
  logic [DIM_LOG-1:0]          l_r;
  logic [DIM_LOG-1:0]          a_r;
  logic [DIM_LOG-1:0]          arow_r;
  logic signed [SAMPLE_W-1:0]  rd_data_r;
  logic signed [TW_W-1:0]      cos_r;
  logic signed [TW_W-1:0]      sin_r;
  logic                        s1_v_r;
  logic                        s1_last_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_re_r;
  logic signed [SAMPLE_W-1:0]  out_im_r;
  logic                        in_fire;
  logic                        start;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ROM_IDX_W-1:0]        j_idx;
  logic                        fin_go;
  mac_ctl_t                    mac_ctl;
  logic signed [ACC_W-1:0]     acc_re;
  logic signed [ACC_W-1:0]     acc_im;
  logic                        mac_done;

  function automatic logic signed [SAMPLE_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0]        biased;
    logic signed [ACC_W-1:0] q;
    logic                    fits;
    biased = acc[ACC_W-1] ? (acc + BIAS) : acc;
    q      = $signed(biased) >>> SHIFT;
    fits   = (&q[ACC_W-1:SAMPLE_W-1]) || !(|q[ACC_W-1:SAMPLE_W-1]);
    if (fits) begin
      return q[SAMPLE_W-1:0];
    end else if (q[ACC_W-1]) begin
      return $signed({1'b1, {(SAMPLE_W-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
    end
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign start       = in_fire && (in_ch.func == FUNC_QUERY);
  assign wr_en       = in_fire && (in_ch.func == FUNC_LOAD)
                       && (int'(in_ch.row_index) < DIM) && (int'(in_ch.col_index) < DIM);
  assign wr_addr     = {DIM_LOG'(in_ch.row_index), DIM_LOG'(in_ch.col_index)};
  assign j_idx       = ROM_IDX_W'(a_r) << ROM_SHIFT;
  assign fin_go      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.sample_value;
    end
    rd_data_r <= mem[cnt_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_RUN;
      ST_RUN:   if (cnt_r == ADDR_LAST) state_nxt = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_v_r      <= 1'b0;
      s1_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      s1_v_r    <= (state_r == ST_RUN);
      s1_last_r <= (state_r == ST_RUN) && (cnt_r == ADDR_LAST);
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r    <= DIM_LOG'(in_ch.freq_row);
      l_r    <= DIM_LOG'(in_ch.freq_col);
      cnt_r  <= '0;
      a_r    <= '0;
      arow_r <= '0;
    end else if (state_r == ST_RUN) begin
      cnt_r <= cnt_r + ADDR_W'(1);
      if (cnt_r[DIM_LOG-1:0] == COL_LAST) begin
        arow_r <= arow_r + k_r;
        a_r    <= arow_r + k_r;
      end else begin
        a_r <= a_r + l_r;
      end
    end
    cos_r <= rom_sine(j_idx + ROM_IDX_W'(QUARTER));
    sin_r <= rom_sine(j_idx);
    if (fin_go) begin
      out_re_r <= scale_sat(acc_re);
      out_im_r <= scale_sat(acc_im);
    end
  end

  assign mac_ctl.clear = start;
  assign mac_ctl.valid = s1_v_r;
  assign mac_ctl.last  = s1_last_r;

  d2c_mac #(
    .DIM (DIM)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (rd_data_r),
    .tw_cos (cos_r),
    .tw_sin (sin_r),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .done   (mac_done)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.real_part = out_re_r;
  assign out_ch.imag_part = out_im_r;

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_DRAIN))
    else $error("accumulation finished outside drain");

  a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == ADDR_LAST) |=> (state_r == ST_DRAIN))
    else $error("walk did not end after last sample");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result word raised without a finished query");

  a_no_mac_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !s1_v_r)
    else $error("MAC fed while idle");

endmodule

FILE: bench/d2c_coefficient_checker.sv
// ----------------------------------------------------------------------------
// d2c_coefficient_checker
// Watches the input and result channels of the 2-D DFT coefficient engine.
// Keeps a shadow copy of the sample matrix. For every accepted query word it
// computes the expected coefficient and queues it. Every result word is
// compared with the oldest queued coefficient.
// ----------------------------------------------------------------------------
module d2c_coefficient_checker (
  input  logic clk,
  input  logic rst_n,
  d2c_in_if    in_ch,
  d2c_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_count,
  output int   result_count
);
  import d2c_pkg::*;

  localparam int     DIM   = DIM_DEF;
  localparam int     CELLS = DIM * DIM;
  localparam longint SCALE = longint'(CELLS) * 16384;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } coeff_t;

  logic signed [SAMPLE_W-1:0] sample_mem [CELLS];
  coeff_t                     coeff_queue [$];

  function automatic int sine_q14(input int j);
    int quad;
    int rem;
    quad = (j >> 4) & 3;
    rem  = j & 15;
    case (quad)
      0:       return int'(QSINE[rem]);
      1:       return int'(QSINE[QUARTER - rem]);
      2:       return -int'(QSINE[rem]);
      default: return -int'(QSINE[QUARTER - rem]);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_q88(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic coeff_t dft_coefficient(input logic [IDX_W-1:0] k,
                                             input logic [IDX_W-1:0] l);
    longint acc_re;
    longint acc_im;
    longint x;
    int     angle;
    int     j;
    int     m;
    int     n;
    coeff_t c;
    acc_re = 0;
    acc_im = 0;
    for (m = 0; m < DIM; m++) begin
      for (n = 0; n < DIM; n++) begin
        angle  = (int'(k) * m + int'(l) * n) % DIM;
        j      = (angle * (ROM_POINTS / DIM)) % ROM_POINTS;
        x      = sample_mem[m * DIM + n];
        acc_re = acc_re + x * sine_q14((j + QUARTER) % ROM_POINTS);
        acc_im = acc_im - x * sine_q14(j);
      end
    end
    c.re = sat_q88(acc_re / SCALE);
    c.im = sat_q88(acc_im / SCALE);
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    coeff_t want;
    if (!rst_n) begin
      mismatch_count = 0;
      result_count   = 0;
      pending_count  = 0;
      coeff_queue.delete();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        if (in_ch.func == FUNC_LOAD) begin
          if (in_ch.row_index < DIM && in_ch.col_index < DIM)
            sample_mem[in_ch.row_index * DIM + in_ch.col_index] = in_ch.sample_value;
        end else begin
          coeff_queue.push_back(dft_coefficient(in_ch.freq_row, in_ch.freq_col));
        end
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (coeff_queue.size() == 0) begin
          report_mismatch($sformatf("result word with no query pending: re=%0d im=%0d",
                                    out_ch.real_part, out_ch.imag_part));
        end else begin
          want = coeff_queue.pop_front();
          result_count++;
          if (out_ch.real_part !== want.re)
            report_mismatch($sformatf("real_part got %0d want %0d",
                                      out_ch.real_part, want.re));
          if (out_ch.imag_part !== want.im)
            report_mismatch($sformatf("imag_part got %0d want %0d",
                                      out_ch.imag_part, want.im));
        end
      end
      pending_count = coeff_queue.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the 2-D DFT coefficient engine. Fills the whole sample matrix,
// runs a directed set of corner loads and queries, then random load and query
// words under three idling patterns on the two channels. Checking is done by
// the coefficient checker instantiated beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import d2c_pkg::*;

  localparam int DIM             = DIM_DEF;
  localparam int CELLS           = DIM * DIM;
  localparam int QUERY_CYCLES    = CELLS + 5;
  localparam int WORDS_PER_PHASE = 193;
  localparam int QUERY_PCT       = 22;
  localparam int DRAIN_LIMIT     = 100000;

  typedef struct {
    logic                       func;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           col_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [IDX_W-1:0]           freq_row;
    logic [IDX_W-1:0]           freq_col;
  } in_word_t;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   mismatch_count;
  int   pending_count;
  int   result_count;
  int   load_words;
  int   query_words;

  d2c_in_if  in_bus ();
  d2c_out_if out_bus ();

  dft2d_coefficient #(.DIM(DIM)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  d2c_coefficient_checker coeff_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_bus),
    .out_ch         (out_bus),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .result_count   (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($signed($urandom_range(511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_word(input logic func);
    in_word_t w;
    w.func         = func;
    w.row_index    = IDX_W'($urandom);
    w.col_index    = IDX_W'($urandom);
    w.sample_value = pick_sample();
    w.freq_row     = IDX_W'($urandom);
    w.freq_col     = IDX_W'($urandom);
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.func         <= w.func;
    in_bus.row_index    <= w.row_index;
    in_bus.col_index    <= w.col_index;
    in_bus.sample_value <= w.sample_value;
    in_bus.freq_row     <= w.freq_row;
    in_bus.freq_col     <= w.freq_col;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (w.func == FUNC_LOAD) load_words++;
    else query_words++;
  endtask

  task automatic send_load(input int row, input int col,
                           input logic signed [SAMPLE_W-1:0] value);
    in_word_t w;
    w              = random_word(FUNC_LOAD);
    w.row_index    = IDX_W'(row);
    w.col_index    = IDX_W'(col);
    w.sample_value = value;
    send_word(w);
  endtask

  task automatic send_query(input int k, input int l);
    in_word_t w;
    w          = random_word(FUNC_QUERY);
    w.freq_row = IDX_W'(k);
    w.freq_col = IDX_W'(l);
    send_word(w);
  endtask

  initial begin
    int drain_cycles;
    int phase;
    int idx;

    rst_n               = 1'b0;
    src_idle_pct        = 0;
    sink_idle_pct       = 0;
    load_words          = 0;
    query_words         = 0;
    in_bus.valid        = 1'b0;
    in_bus.func         = FUNC_LOAD;
    in_bus.row_index    = '0;
    in_bus.col_index    = '0;
    in_bus.sample_value = '0;
    in_bus.freq_row     = '0;
    in_bus.freq_col     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < CELLS; idx++)
      send_load(idx / DIM, idx % DIM, pick_sample());

    send_load(0, 0, 16'sh7FFF);
    send_load(DIM - 1, DIM - 1, 16'sh8000);
    send_load(0, DIM - 1, -16'sd1);
    send_load(DIM - 1, 0, 16'sd1);
    send_query(0, 0);
    send_query(DIM - 1, DIM - 1);
    send_query(DIM / 2, DIM / 2);
    send_query(0, DIM / 2);
    send_query(DIM / 2, 0);
    send_query(1, 0);
    send_query(0, 1);
    send_query(DIM - 1, 1);
    send_load(DIM / 2, 3, 16'sh7FFF);
    send_query(3, DIM - 1);
    send_query(DIM - 1, 0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 7;
          sink_idle_pct = 73;
        end
        1: begin
          src_idle_pct  = 73;
          sink_idle_pct = 7;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (WORDS_PER_PHASE)
        send_word(random_word(($urandom_range(99) < QUERY_PCT) ? FUNC_QUERY : FUNC_LOAD));
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;

    drain_cycles = 0;
    while (pending_count != 0) begin
      if (drain_cycles >= DRAIN_LIMIT) begin
        $display("timeout with %0d coefficients outstanding", pending_count);
        $display("TEST FAILED");
        $finish;
      end
      @(negedge clk);
      drain_cycles++;
    end
    repeat (QUERY_CYCLES + 20) @(negedge clk);

    $display("covered %0d load words and %0d query words, %0d coefficients checked",
             load_words, query_words, result_count);
    $display("idling patterns: sender light/receiver heavy, reversed, and none");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/d2c_pkg.sv
sv/d2c_if.sv
sv/d2c_mac.sv
sv/dft2d_coefficient.sv
bench/d2c_coefficient_checker.sv
bench/testbench.sv
